// File: rtl/core/lai_pkg.sv
// ----------------------------------------------------------------------------
// lai_pkg
// types and constants shared by the leaky anti-windup integrator
// ----------------------------------------------------------------------------
package lai_pkg;

  localparam int unsigned LeakW    = 17;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned IlimW    = 31;
  localparam int unsigned SlimW    = 16;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned IntegW   = 32;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned FracShift = 16;

  localparam logic [LeakW-1:0]   LeakReset   = 17'd65536;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd655;
  localparam logic [IlimW-1:0]   IlimReset   = 31'h7fff_ffff;
  localparam logic [SlimW-1:0]   SlimReset   = 16'hffff;

  typedef enum logic [CfgAddrW-1:0] {
    REG_LEAK   = 2'd0,
    REG_PERIOD = 2'd1,
    REG_ILIM   = 2'd2,
    REG_SLIM   = 2'd3
  } cfg_reg_t;

endpackage

// File: rtl/core/leaky_antiwindup_integrator_top.sv
// ----------------------------------------------------------------------------
// leaky_antiwindup_integrator_top
// slew-limited leaky integrator with symmetric anti-windup clamp
// ----------------------------------------------------------------------------
// One result word per input word, one word per clock sustained while out_tready
// does not stall the output. A word sits in the input register, then the slew
// clamp, both products, the floor shift and the output clamp run combinationally
// into the output register, and the held integrand and integral update in the
// same cycle as it, which lets the next word follow directly. Standstill or
// a sign reversal of the limited sample clears both held values and yields a
// zero result. Configuration is written through cfg_we/cfg_addr/cfg_wdata.
// ----------------------------------------------------------------------------
module leaky_antiwindup_integrator_top
  import lai_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // [15:0] integrand
  input  logic                in_tuser,   // [0] standstill
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // [31:0] integral
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic [LeakW-1:0]   leak_r;
  logic [PeriodW-1:0] period_r;
  logic [IlimW-1:0]   ilim_r;
  logic [SlimW-1:0]   slim_r;

  logic                       s1_valid_r;
  logic signed [SampleW-1:0]  s1_sample_r;
  logic                       s1_still_r;

  logic signed [SampleW-1:0]  held_integrand_r;
  logic signed [IntegW-1:0]   held_integral_r;

  logic                       out_valid_r;
  logic [IntegW-1:0]          out_data_r;

  logic                       advance;

  logic signed [17:0] lo_val;
  logic signed [17:0] hi_val;
  logic signed [17:0] s_wide;
  logic signed [SampleW-1:0] s_lim;
  logic               reversal;
  logic               clear;
  logic signed [49:0] prod_leak;
  logic signed [49:0] prod_sample;
  logic signed [49:0] acc;
  logic signed [33:0] shifted;
  logic signed [33:0] lim_pos;
  logic signed [33:0] lim_neg;
  logic signed [33:0] clamped;
  logic signed [SampleW-1:0] held_integrand_nxt;
  logic signed [IntegW-1:0]  held_integral_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_r   <= LeakReset;
      period_r <= PeriodReset;
      ilim_r   <= IlimReset;
      slim_r   <= SlimReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_LEAK:   leak_r   <= cfg_wdata[LeakW-1:0];
        REG_PERIOD: period_r <= cfg_wdata[PeriodW-1:0];
        REG_ILIM:   ilim_r   <= cfg_wdata[IlimW-1:0];
        REG_SLIM:   slim_r   <= cfg_wdata[SlimW-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sample_r <= $signed(in_tdata);
      s1_still_r  <= in_tuser;
    end
  end

  // slew clamp and reversal check
  always_comb begin
    lo_val = 18'(held_integrand_r) - $signed({2'b00, slim_r});
    hi_val = 18'(held_integrand_r) + $signed({2'b00, slim_r});
    s_wide = 18'(s1_sample_r);
    if (s_wide < lo_val) begin
      s_wide = lo_val;
    end
    if (s_wide > hi_val) begin
      s_wide = hi_val;
    end
    if (s_wide < -18'sd32768) begin
      s_lim = -16'sd32768;
    end else if (s_wide > 18'sd32767) begin
      s_lim = 16'sd32767;
    end else begin
      s_lim = s_wide[SampleW-1:0];
    end
    reversal = ((s_lim > 0) && (held_integrand_r < 0)) ||
               ((s_lim < 0) && (held_integrand_r > 0));
    clear    = s1_still_r || reversal;
  end

  // leak and gain, floor shift, anti-windup clamp
  always_comb begin
    prod_leak   = 50'(held_integral_r) * $signed({33'd0, leak_r});
    prod_sample = 50'(s_lim) * $signed({34'd0, period_r});
    acc         = prod_leak + prod_sample;
    shifted     = 34'(acc >>> FracShift);
    lim_pos     = $signed({3'b000, ilim_r});
    lim_neg     = -lim_pos;
    clamped     = shifted;
    if (clamped > lim_pos) begin
      clamped = lim_pos;
    end
    if (clamped < lim_neg) begin
      clamped = lim_neg;
    end
    if (clear) begin
      held_integrand_nxt = '0;
      held_integral_nxt  = '0;
    end else begin
      held_integrand_nxt = s_lim;
      held_integral_nxt  = clamped[IntegW-1:0];
    end
  end

  // held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_integrand_r <= '0;
      held_integral_r  <= '0;
    end else if (advance) begin
      held_integrand_r <= held_integrand_nxt;
      held_integral_r  <= held_integral_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= held_integral_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
